[hdl/dmcp_pkg.sv]
// Shared types, codes and defaults of the demand mapping cache policy core.
// Used by the controller, datapath and top level; depends on nothing.
package dmcp_pkg;

  localparam int unsigned MapPagesDef         = 65536;
  localparam int unsigned RealSlotsDef        = 64;
  localparam int unsigned GhostSlotsDef       = 16;
  localparam int unsigned EntriesPerTransDef  = 512;
  localparam int unsigned SectorsPerPageDef   = 4;

  localparam logic [15:0] TrpReset = 16'd128;

  localparam logic [1:0] StInvalid = 2'd0;
  localparam logic [1:0] StReal    = 2'd1;
  localparam logic [1:0] StGhost   = 2'd2;

  localparam logic [2:0] CmdReadTrans  = 3'd0;
  localparam logic [2:0] CmdWriteTrans = 3'd1;
  localparam logic [2:0] CmdReadData   = 3'd2;
  localparam logic [2:0] CmdWriteData  = 3'd3;
  localparam logic [2:0] CmdRangeErr   = 3'd4;

  typedef struct packed {
    logic [15:0] logical_page;
    logic        is_read;
    logic        request_end;
  } dmcp_in_t;

  typedef struct packed {
    logic [2:0]  command_kind;
    logic [17:0] flash_sector;
    logic        last_of_item;
    logic        request_done;
  } dmcp_out_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        dirty;
    logic [31:0] age;
  } dmcp_entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_RD_P,
    OP_CAP_CUR,
    OP_INC_P,
    OP_SINIT_R,
    OP_SINIT_G,
    OP_SCAN,
    OP_RD_MIN,
    OP_RD_NEW,
    OP_CAP_OTH,
    OP_NEWEST_IF,
    OP_SWAP,
    OP_SWAP2,
    OP_DIV_MIN,
    OP_DIV_P,
    OP_EMIT_T0,
    OP_EMIT_T1,
    OP_EVICT,
    OP_DEMOTE,
    OP_INSTALL,
    OP_FINAL
  } dmcp_op_e;

  typedef struct packed {
    logic       clr_last;
    logic       err;
    logic [1:0] status;
    logic       rfull;
    logic       gfull;
    logic       min_vld;
    logic       age_le;
    logic       oth_dirty;
    logic       match_vld;
    logic       rfree_vld;
    logic       scan_done;
    logic       div_done;
    logic       out_free;
  } dmcp_stat_t;

endpackage

[hdl/dmcp_div.sv]
// Divider by the constant entries-per-translation-page, by reciprocal multiplication
// in three 32x16 partial products. Depends on nothing; used by the datapath.
module dmcp_div #(
  parameter int unsigned ENTRIES_PER_TRANS_PAGE = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam int unsigned K     = $clog2(ENTRIES_PER_TRANS_PAGE);
  localparam int unsigned SH    = 32 + K;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(ENTRIES_PER_TRANS_PAGE) - 64'd1) /
                                  64'(ENTRIES_PER_TRANS_PAGE);

  logic [31:0] x_q;
  logic [79:0] acc_q, addend;
  logic [47:0] part;
  logic [15:0] chunk;
  logic [1:0]  step_q;
  logic        busy_q, done_q;

  assign chunk  = RECIP[{step_q, 4'b0000} +: 16];
  assign part   = {16'd0, x_q} * {32'd0, chunk};
  assign addend = {32'd0, part} << {step_q, 4'b0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dividend_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q[SH +: 32];

endmodule

[hdl/dmcp_dpath.sv]
// Datapath: page table memory, slot lists, scan pipeline, output register.
// Depends on dmcp_pkg and dmcp_div; driven by dmcp_ctrl commands.
module dmcp_dpath #(
  parameter int unsigned MAP_PAGES              = dmcp_pkg::MapPagesDef,
  parameter int unsigned REAL_SLOTS             = dmcp_pkg::RealSlotsDef,
  parameter int unsigned GHOST_SLOTS            = dmcp_pkg::GhostSlotsDef,
  parameter int unsigned ENTRIES_PER_TRANS_PAGE = dmcp_pkg::EntriesPerTransDef,
  parameter int unsigned SECTORS_PER_PAGE       = dmcp_pkg::SectorsPerPageDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dmcp_pkg::dmcp_op_e   op_i,
  output dmcp_pkg::dmcp_stat_t stat_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  dmcp_pkg::dmcp_in_t   in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output dmcp_pkg::dmcp_out_t  out_data_o
);
  import dmcp_pkg::*;

  localparam int unsigned PW   = $clog2(MAP_PAGES);
  localparam int unsigned RIW  = $clog2(REAL_SLOTS);
  localparam int unsigned GIW  = (GHOST_SLOTS > 1) ? $clog2(GHOST_SLOTS) : 1;
  localparam int unsigned MIW  = (RIW > GIW) ? RIW : GIW;
  localparam int unsigned RCW  = $clog2(REAL_SLOTS + 1);
  localparam int unsigned GCW  = $clog2(GHOST_SLOTS + 1);
  localparam int unsigned NMAX = (REAL_SLOTS > GHOST_SLOTS) ? REAL_SLOTS : GHOST_SLOTS;
  localparam int unsigned SCW  = $clog2(NMAX + 3);

  function automatic logic [31:0] age_inc(logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  dmcp_entry_t pm [MAP_PAGES];
  logic [PW-1:0] rsp [REAL_SLOTS];
  logic [PW-1:0] gsp [GHOST_SLOTS];

  logic [15:0]   trp_q;
  logic [PW-1:0] clr_q, p_q, newest_q, min_page_q, s1_page, s2_page_q;
  logic          rd_q, end_q, err_q;
  dmcp_entry_t   cur_q, oth_q, pm_rdata_q, inc_entry, inst_entry, pm_wdata;
  logic [PW-1:0] rsp_rd_q, gsp_rd_q, pm_raddr, pm_waddr;
  logic          pm_re, pm_we, rsp_we, gsp_we, rsp_re, gsp_re;
  logic [RIW-1:0] rsp_waddr;
  logic [GIW-1:0] gsp_waddr;
  logic [RCW-1:0] rcnt_q;
  logic [GCW-1:0] gcnt_q;
  logic [REAL_SLOTS-1:0]  real_used_q;
  logic [GHOST_SLOTS-1:0] ghost_used_q;
  logic [SCW-1:0] cnt_q, scan_n;
  logic          scan_g_q, s1v_q, s2v_q, s1_used_q, s2_used_q;
  logic [MIW-1:0] s1_idx_q, s2_idx_q, min_idx_q;
  logic          min_vld_q, rfree_vld_q, gfree_vld_q, match_vld_q;
  logic [31:0]   min_age_q;
  logic [RIW-1:0] rfree_idx_q;
  logic [GIW-1:0] gfree_idx_q, match_idx_q;
  logic          s0_act, s0_used, s2_take, s1_match, out_valid_q, out_free;
  dmcp_out_t     out_q;
  logic [16:0]   sum;
  logic          div_start, div_done;
  logic [31:0]   div_dividend, quot, tprod, dprod;

  assign sum       = {1'b0, in_data_i.logical_page} + {1'b0, trp_q};
  assign scan_n    = scan_g_q ? SCW'(GHOST_SLOTS) : SCW'(REAL_SLOTS);
  assign s0_act    = (op_i == OP_SCAN) && (cnt_q < scan_n);
  assign s0_used   = scan_g_q ? ghost_used_q[cnt_q[GIW-1:0]] : real_used_q[cnt_q[RIW-1:0]];
  assign s1_page   = scan_g_q ? gsp_rd_q : rsp_rd_q;
  assign s1_match  = (op_i == OP_SCAN) && s1v_q && scan_g_q && s1_used_q &&
                     (s1_page == p_q) && !match_vld_q;
  assign s2_take   = (op_i == OP_SCAN) && s2v_q && s2_used_q &&
                     (!min_vld_q || (pm_rdata_q.age <= min_age_q));
  assign rsp_re    = s0_act && !scan_g_q;
  assign gsp_re    = s0_act && scan_g_q;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    inc_entry        = cur_q;
    inc_entry.age    = age_inc(cur_q.age);
    inst_entry       = cur_q;
    inst_entry.status = StReal;
    inst_entry.age   = age_inc(oth_q.age);
  end

  assign div_start    = (op_i == OP_DIV_MIN) || (op_i == OP_DIV_P);
  assign div_dividend = (op_i == OP_DIV_MIN) ? 32'(min_page_q) - 32'(trp_q)
                                             : 32'(p_q) - 32'(trp_q);
  assign tprod = quot * 32'(SECTORS_PER_PAGE);
  assign dprod = 32'(p_q) * 32'(SECTORS_PER_PAGE);

  dmcp_div #(.ENTRIES_PER_TRANS_PAGE(ENTRIES_PER_TRANS_PAGE)) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_comb begin
    pm_re     = 1'b0;
    pm_raddr  = p_q;
    pm_we     = 1'b0;
    pm_waddr  = p_q;
    pm_wdata  = cur_q;
    rsp_we    = 1'b0;
    rsp_waddr = min_idx_q[RIW-1:0];
    gsp_we    = 1'b0;
    gsp_waddr = match_idx_q;
    case (op_i)
      OP_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_q;
        pm_wdata = '0;
      end
      OP_RD_P: pm_re = 1'b1;
      OP_INC_P: begin
        pm_we    = 1'b1;
        pm_wdata = inc_entry;
      end
      OP_SCAN: begin
        if (s1v_q) begin
          pm_re    = 1'b1;
          pm_raddr = s1_page;
        end
      end
      OP_RD_MIN: begin
        pm_re    = 1'b1;
        pm_raddr = min_page_q;
      end
      OP_RD_NEW: begin
        pm_re    = 1'b1;
        pm_raddr = newest_q;
      end
      OP_SWAP: begin
        pm_we           = 1'b1;
        pm_wdata.status = StReal;
        rsp_we          = 1'b1;
      end
      OP_SWAP2: begin
        pm_we           = 1'b1;
        pm_waddr        = min_page_q;
        pm_wdata        = oth_q;
        pm_wdata.status = StGhost;
        gsp_we          = 1'b1;
      end
      OP_EVICT: begin
        pm_we           = 1'b1;
        pm_waddr        = min_page_q;
        pm_wdata        = oth_q;
        pm_wdata.status = StInvalid;
        pm_wdata.dirty  = 1'b0;
      end
      OP_DEMOTE: begin
        pm_we           = 1'b1;
        pm_waddr        = min_page_q;
        pm_wdata        = oth_q;
        pm_wdata.status = gfree_vld_q ? StGhost : StInvalid;
        gsp_we          = gfree_vld_q;
        gsp_waddr       = gfree_idx_q;
      end
      OP_INSTALL: begin
        pm_we     = 1'b1;
        pm_wdata  = inst_entry;
        rsp_we    = 1'b1;
        rsp_waddr = rfree_idx_q;
      end
      OP_FINAL: begin
        pm_we          = !err_q && !rd_q;
        pm_wdata.dirty = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pm[pm_waddr] <= pm_wdata;
    if (pm_re) pm_rdata_q <= pm[pm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rsp_we) rsp[rsp_waddr] <= p_q;
    if (rsp_re) rsp_rd_q <= rsp[cnt_q[RIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (gsp_we) gsp[gsp_waddr] <= min_page_q;
    if (gsp_re) gsp_rd_q <= gsp[cnt_q[GIW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trp_q        <= TrpReset;
      clr_q        <= '0;
      err_q        <= 1'b0;
      rcnt_q       <= '0;
      gcnt_q       <= '0;
      newest_q     <= '0;
      real_used_q  <= '0;
      ghost_used_q <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      scan_g_q     <= 1'b0;
      s1v_q        <= 1'b0;
      s2v_q        <= 1'b0;
      min_vld_q    <= 1'b0;
      rfree_vld_q  <= 1'b0;
      gfree_vld_q  <= 1'b0;
      match_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) trp_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (op_i)
        OP_CLEAR: clr_q <= clr_q + PW'(1);
        OP_LOAD:  err_q <= 32'(sum) >= 32'(MAP_PAGES);
        OP_SINIT_R, OP_SINIT_G: begin
          cnt_q     <= '0;
          scan_g_q  <= (op_i == OP_SINIT_G);
          s1v_q     <= 1'b0;
          s2v_q     <= 1'b0;
          min_vld_q <= 1'b0;
          if (op_i == OP_SINIT_G) begin
            gfree_vld_q <= 1'b0;
            match_vld_q <= 1'b0;
          end else begin
            rfree_vld_q <= 1'b0;
          end
        end
        OP_SCAN: begin
          if (cnt_q < scan_n + SCW'(2)) cnt_q <= cnt_q + SCW'(1);
          s1v_q <= s0_act;
          s2v_q <= s1v_q;
          if (s0_act && !s0_used) begin
            if (scan_g_q && !gfree_vld_q) gfree_vld_q <= 1'b1;
            if (!scan_g_q && !rfree_vld_q) rfree_vld_q <= 1'b1;
          end
          if (s1_match) match_vld_q <= 1'b1;
          if (s2_take) min_vld_q <= 1'b1;
        end
        OP_NEWEST_IF: if (oth_q.age <= cur_q.age) newest_q <= p_q;
        OP_EMIT_T0, OP_EMIT_T1: out_valid_q <= 1'b1;
        OP_FINAL: out_valid_q <= 1'b1;
        OP_EVICT: begin
          ghost_used_q[min_idx_q[GIW-1:0]] <= 1'b0;
          if (gcnt_q != '0) gcnt_q <= gcnt_q - GCW'(1);
        end
        OP_DEMOTE: begin
          real_used_q[min_idx_q[RIW-1:0]] <= 1'b0;
          rfree_vld_q <= 1'b1;
          if (gfree_vld_q) begin
            ghost_used_q[gfree_idx_q] <= 1'b1;
            if (rcnt_q != '0) rcnt_q <= rcnt_q - RCW'(1);
            gcnt_q <= gcnt_q + GCW'(1);
          end else if (rcnt_q != '0) begin
            rcnt_q <= rcnt_q - RCW'(1);
          end
        end
        OP_INSTALL: begin
          newest_q <= p_q;
          real_used_q[rfree_idx_q] <= 1'b1;
          rcnt_q <= rcnt_q + RCW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        p_q   <= sum[PW-1:0];
        rd_q  <= in_data_i.is_read;
        end_q <= in_data_i.request_end;
      end
      OP_CAP_CUR: cur_q <= pm_rdata_q;
      OP_INC_P:   cur_q <= inc_entry;
      OP_CAP_OTH: oth_q <= pm_rdata_q;
      OP_SWAP:    cur_q.status <= StReal;
      OP_INSTALL: cur_q <= inst_entry;
      OP_DEMOTE:  rfree_idx_q <= min_idx_q[RIW-1:0];
      OP_SCAN: begin
        s1_idx_q  <= cnt_q[MIW-1:0];
        s1_used_q <= s0_used;
        s2_idx_q  <= s1_idx_q;
        s2_used_q <= s1_used_q;
        s2_page_q <= s1_page;
        if (s0_act && !s0_used) begin
          if (scan_g_q && !gfree_vld_q) gfree_idx_q <= cnt_q[GIW-1:0];
          if (!scan_g_q && !rfree_vld_q) rfree_idx_q <= cnt_q[RIW-1:0];
        end
        if (s1_match) match_idx_q <= s1_idx_q[GIW-1:0];
        if (s2_take) begin
          min_idx_q  <= s2_idx_q;
          min_age_q  <= pm_rdata_q.age;
          min_page_q <= s2_page_q;
        end
      end
      OP_EMIT_T0: out_q <= '{CmdReadTrans, tprod[17:0], 1'b0, 1'b0};
      OP_EMIT_T1: out_q <= '{CmdWriteTrans, tprod[17:0], 1'b0, 1'b0};
      OP_FINAL: begin
        if (err_q) out_q <= '{CmdRangeErr, 18'd0, 1'b1, end_q};
        else out_q <= '{rd_q ? CmdReadData : CmdWriteData, dprod[17:0], 1'b1, end_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.clr_last  = clr_q == PW'(MAP_PAGES - 1);
    stat_o.err       = err_q;
    stat_o.status    = cur_q.status;
    stat_o.rfull     = rcnt_q >= RCW'(REAL_SLOTS);
    stat_o.gfull     = gcnt_q >= GCW'(GHOST_SLOTS);
    stat_o.min_vld   = min_vld_q;
    stat_o.age_le    = oth_q.age <= cur_q.age;
    stat_o.oth_dirty = oth_q.dirty;
    stat_o.match_vld = match_vld_q;
    stat_o.rfree_vld = rfree_vld_q;
    stat_o.scan_done = cnt_q == scan_n + SCW'(2);
    stat_o.div_done  = div_done;
    stat_o.out_free  = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/dmcp_ctrl.sv]
// Controller state machine: sequences clearing, lookup, scans, eviction and output.
// Depends on dmcp_pkg; issues commands to dmcp_dpath and reads its status.
module dmcp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dmcp_pkg::dmcp_stat_t stat_i,
  output dmcp_pkg::dmcp_op_e   op_o
);
  import dmcp_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_RD_P, S_CAP, S_DISPATCH,
    S_GH_INC, S_GH_GINIT, S_GH_GSCAN, S_GH_RINIT, S_GH_RSCAN,
    S_GH_RD, S_GH_CAP, S_GH_CHK, S_GH_SWAP, S_GH_SWAP2,
    S_RH_INC, S_RH_RD, S_RH_CAP, S_RH_CHK,
    S_EG_INIT, S_EG_SCAN, S_EG_RD, S_EG_CAP, S_EG_CHK, S_EG_DIV, S_EG_WAIT,
    S_EG_EM0, S_EG_EM1, S_EG_EVICT,
    S_FG_INIT, S_FG_SCAN, S_R_INIT, S_R_SCAN,
    S_D_RD, S_D_CAP, S_D_DEM,
    S_T_DIV, S_T_WAIT, S_T_EM,
    S_N_RD, S_N_CAP, S_INST, S_FINAL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        op_o = OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_RD_P;
        end
      end
      S_RD_P: begin op_o = OP_RD_P; state_d = S_CAP; end
      S_CAP:  begin op_o = OP_CAP_CUR; state_d = S_DISPATCH; end
      S_DISPATCH: begin
        if (stat_i.err) state_d = S_FINAL;
        else if (stat_i.status == StGhost) state_d = S_GH_INC;
        else if (stat_i.status == StReal) state_d = S_RH_INC;
        else if (stat_i.rfull) state_d = stat_i.gfull ? S_EG_INIT : S_FG_INIT;
        else state_d = S_R_INIT;
      end
      S_GH_INC:   begin op_o = OP_INC_P; state_d = S_GH_GINIT; end
      S_GH_GINIT: begin op_o = OP_SINIT_G; state_d = S_GH_GSCAN; end
      S_GH_GSCAN: begin
        op_o = OP_SCAN;
        if (stat_i.scan_done) state_d = S_GH_RINIT;
      end
      S_GH_RINIT: begin op_o = OP_SINIT_R; state_d = S_GH_RSCAN; end
      S_GH_RSCAN: begin
        op_o = OP_SCAN;
        if (stat_i.scan_done) state_d = stat_i.min_vld ? S_GH_RD : S_FINAL;
      end
      S_GH_RD:  begin op_o = OP_RD_MIN; state_d = S_GH_CAP; end
      S_GH_CAP: begin op_o = OP_CAP_OTH; state_d = S_GH_CHK; end
      S_GH_CHK: state_d = (stat_i.age_le && stat_i.match_vld) ? S_GH_SWAP : S_FINAL;
      S_GH_SWAP:  begin op_o = OP_SWAP; state_d = S_GH_SWAP2; end
      S_GH_SWAP2: begin op_o = OP_SWAP2; state_d = S_FINAL; end
      S_RH_INC: begin op_o = OP_INC_P; state_d = S_RH_RD; end
      S_RH_RD:  begin op_o = OP_RD_NEW; state_d = S_RH_CAP; end
      S_RH_CAP: begin op_o = OP_CAP_OTH; state_d = S_RH_CHK; end
      S_RH_CHK: begin op_o = OP_NEWEST_IF; state_d = S_FINAL; end
      S_EG_INIT: begin op_o = OP_SINIT_G; state_d = S_EG_SCAN; end
      S_EG_SCAN: begin
        op_o = OP_SCAN;
        if (stat_i.scan_done) state_d = stat_i.min_vld ? S_EG_RD : S_FG_INIT;
      end
      S_EG_RD:  begin op_o = OP_RD_MIN; state_d = S_EG_CAP; end
      S_EG_CAP: begin op_o = OP_CAP_OTH; state_d = S_EG_CHK; end
      S_EG_CHK: state_d = stat_i.oth_dirty ? S_EG_DIV : S_EG_EVICT;
      S_EG_DIV: begin op_o = OP_DIV_MIN; state_d = S_EG_WAIT; end
      S_EG_WAIT: if (stat_i.div_done) state_d = S_EG_EM0;
      S_EG_EM0: begin
        if (stat_i.out_free) begin
          op_o    = OP_EMIT_T0;
          state_d = S_EG_EM1;
        end
      end
      S_EG_EM1: begin
        if (stat_i.out_free) begin
          op_o    = OP_EMIT_T1;
          state_d = S_EG_EVICT;
        end
      end
      S_EG_EVICT: begin op_o = OP_EVICT; state_d = S_FG_INIT; end
      S_FG_INIT:  begin op_o = OP_SINIT_G; state_d = S_FG_SCAN; end
      S_FG_SCAN: begin
        op_o = OP_SCAN;
        if (stat_i.scan_done) state_d = S_R_INIT;
      end
      S_R_INIT: begin op_o = OP_SINIT_R; state_d = S_R_SCAN; end
      S_R_SCAN: begin
        op_o = OP_SCAN;
        if (stat_i.scan_done) state_d = (stat_i.rfull && stat_i.min_vld) ? S_D_RD : S_T_DIV;
      end
      S_D_RD:  begin op_o = OP_RD_MIN; state_d = S_D_CAP; end
      S_D_CAP: begin op_o = OP_CAP_OTH; state_d = S_D_DEM; end
      S_D_DEM: begin op_o = OP_DEMOTE; state_d = S_T_DIV; end
      S_T_DIV: begin op_o = OP_DIV_P; state_d = S_T_WAIT; end
      S_T_WAIT: if (stat_i.div_done) state_d = S_T_EM;
      S_T_EM: begin
        if (stat_i.out_free) begin
          op_o    = OP_EMIT_T0;
          state_d = stat_i.rfree_vld ? S_N_RD : S_FINAL;
        end
      end
      S_N_RD:  begin op_o = OP_RD_NEW; state_d = S_N_CAP; end
      S_N_CAP: begin op_o = OP_CAP_OTH; state_d = S_INST; end
      S_INST:  begin op_o = OP_INSTALL; state_d = S_FINAL; end
      S_FINAL: begin
        if (stat_i.out_free) begin
          op_o    = OP_FINAL;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

[hdl/demand_mapping_cache_policy_core.sv]
// Top level of the demand mapping cache policy core.
// Depends on dmcp_pkg, dmcp_ctrl, dmcp_dpath (and dmcp_div below it).
//
// Input channel in_valid_i/in_ready_o carries one page access per transaction;
// output channel out_valid_o/out_ready_i carries one flash command per
// transaction, one to four per access, the last one flagged last_of_item.
// cfg_we_i/cfg_wdata_i write the translation region size; the user must write it
// only while idle, the block does not enforce this. After reset a clearing pass
// writes every page table entry (MAP_PAGES, 65536 by default), one per cycle;
// in_ready_o stays low during it. One access is in flight at a time. A miss
// runs up to two ghost list scans and one real list scan, and one or two
// reciprocal divisions for translation sectors. Scans are paced by the
// single-port page table read, one slot a cycle.
// Results sit in one output register; a stalled receiver holds the block
// before its next command, while the next access may already be taken.
module demand_mapping_cache_policy_core #(
  parameter int unsigned MAP_PAGES              = dmcp_pkg::MapPagesDef,
  parameter int unsigned REAL_SLOTS             = dmcp_pkg::RealSlotsDef,
  parameter int unsigned GHOST_SLOTS            = dmcp_pkg::GhostSlotsDef,
  parameter int unsigned ENTRIES_PER_TRANS_PAGE = dmcp_pkg::EntriesPerTransDef,
  parameter int unsigned SECTORS_PER_PAGE       = dmcp_pkg::SectorsPerPageDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dmcp_pkg::dmcp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dmcp_pkg::dmcp_out_t out_data_o
);
  import dmcp_pkg::*;

  dmcp_op_e   op;
  dmcp_stat_t stat;

  dmcp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .stat_i(stat),
    .op_o  (op)
  );

  dmcp_dpath #(
    .MAP_PAGES             (MAP_PAGES),
    .REAL_SLOTS            (REAL_SLOTS),
    .GHOST_SLOTS           (GHOST_SLOTS),
    .ENTRIES_PER_TRANS_PAGE(ENTRIES_PER_TRANS_PAGE),
    .SECTORS_PER_PAGE      (SECTORS_PER_PAGE)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .op_i  (op),
    .stat_o(stat),
    .cfg_we_i,
    .cfg_wdata_i,
    .in_data_i,
    .out_ready_i,
    .out_valid_o,
    .out_data_o
  );

endmodule
